FILE: rtl/core/tlik_pkg.sv
package tlik_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_W = 52;
  localparam int ANG_W = 32;

  localparam logic signed [ANG_W-1:0] HALF_PI = 32'sd421657428;

  typedef enum logic [1:0] {
    REG_UPPER_LEN = 2'd0,
    REG_LOWER_LEN = 2'd1,
    REG_HIP_OFF   = 2'd2,
    REG_KNEE_OFF  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [23:0] tip_x;
    logic signed [23:0] tip_y;
    logic               mirror;
  } ik_in_t;

  typedef struct packed {
    logic signed [23:0] hip_angle;
    logic signed [23:0] knee_angle;
    logic               unreachable;
  } ik_out_t;

  function automatic logic signed [ANG_W-1:0] atan_rom(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4193963;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      5'd24: v = 32'sd16;
      5'd25: v = 32'sd8;
      5'd26: v = 32'sd4;
      5'd27: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/tlik_isqrt.sv
module tlik_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  localparam int STEPS = 32;

  logic [63:0] src      [STEPS];
  logic [35:0] rem      [STEPS];
  logic [31:0] res      [STEPS];
  logic [63:0] src_next [STEPS];
  logic [35:0] rem_next [STEPS];
  logic [31:0] res_next [STEPS];

  always_comb begin
    for (int j = 0; j < STEPS; j++) begin
      logic [63:0] s;
      logic [35:0] r;
      logic [31:0] q;
      logic [35:0] acc;
      logic [35:0] trial;
      if (j == 0) begin
        s = rad;
        r = '0;
        q = '0;
      end else begin
        s = src[j-1];
        r = rem[j-1];
        q = res[j-1];
      end
      acc   = {r[33:0], s[63:62]};
      trial = {2'b00, q, 2'b01};
      if (acc >= trial) begin
        rem_next[j] = acc - trial;
        res_next[j] = {q[30:0], 1'b1};
      end else begin
        rem_next[j] = acc;
        res_next[j] = {q[30:0], 1'b0};
      end
      src_next[j] = {s[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < STEPS; j++) begin
        src[j] <= src_next[j];
        rem[j] <= rem_next[j];
        res[j] <= res_next[j];
      end
    end
  end

  assign root = res[STEPS-1];

endmodule

FILE: rtl/core/tlik_divider.sv
module tlik_divider (
  input  logic        clk,
  input  logic        en,
  input  logic [56:0] mag,
  input  logic [56:0] den,
  output logic [30:0] quot
);

  localparam int STEPS = 31;

  logic [56:0] rem      [STEPS];
  logic [56:0] dvs      [STEPS];
  logic [30:0] quo      [STEPS];
  logic [56:0] rem_next [STEPS];
  logic [56:0] dvs_next [STEPS];
  logic [30:0] quo_next [STEPS];

  always_comb begin
    for (int j = 0; j < STEPS; j++) begin
      logic [57:0] sh;
      logic [57:0] diff;
      logic        ge;
      if (j == 0) begin
        ge          = mag >= den;
        sh          = {1'b0, mag};
        diff        = {1'b0, mag} - {1'b0, den};
        rem_next[j] = ge ? diff[56:0] : sh[56:0];
        quo_next[j] = {30'd0, ge};
        dvs_next[j] = den;
      end else begin
        sh          = {rem[j-1], 1'b0};
        ge          = sh >= {1'b0, dvs[j-1]};
        diff        = sh - {1'b0, dvs[j-1]};
        rem_next[j] = ge ? diff[56:0] : sh[56:0];
        quo_next[j] = {quo[j-1][29:0], ge};
        dvs_next[j] = dvs[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < STEPS; j++) begin
        rem[j] <= rem_next[j];
        dvs[j] <= dvs_next[j];
        quo[j] <= quo_next[j];
      end
    end
  end

  assign quot = quo[STEPS-1];

endmodule

FILE: rtl/core/tlik_cordic.sv
module tlik_cordic (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tlik_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [tlik_pkg::CORDIC_W-1:0] y_in,
  output logic signed [tlik_pkg::ANG_W-1:0]    angle
);

  localparam int STAGES = tlik_pkg::CORDIC_STEPS + 1;

  logic signed [tlik_pkg::CORDIC_W-1:0] xr     [STAGES];
  logic signed [tlik_pkg::CORDIC_W-1:0] yr     [STAGES];
  logic signed [tlik_pkg::ANG_W-1:0]    zr     [STAGES];
  logic signed [tlik_pkg::CORDIC_W-1:0] x_next [STAGES];
  logic signed [tlik_pkg::CORDIC_W-1:0] y_next [STAGES];
  logic signed [tlik_pkg::ANG_W-1:0]    z_next [STAGES];

  always_comb begin
    for (int j = 0; j < STAGES; j++) begin
      logic signed [tlik_pkg::CORDIC_W-1:0] xs;
      logic signed [tlik_pkg::CORDIC_W-1:0] ys;
      logic signed [tlik_pkg::ANG_W-1:0]    rom;
      if (j == 0) begin
        xs  = '0;
        ys  = '0;
        rom = '0;
        if (x_in < 0) begin
          if (y_in >= 0) begin
            x_next[j] = y_in;
            y_next[j] = -x_in;
            z_next[j] = tlik_pkg::HALF_PI;
          end else begin
            x_next[j] = -y_in;
            y_next[j] = x_in;
            z_next[j] = -tlik_pkg::HALF_PI;
          end
        end else begin
          x_next[j] = x_in;
          y_next[j] = y_in;
          z_next[j] = '0;
        end
      end else begin
        xs  = xr[j-1] >>> (j - 1);
        ys  = yr[j-1] >>> (j - 1);
        rom = tlik_pkg::atan_rom(5'(j - 1));
        if (yr[j-1] >= 0) begin
          x_next[j] = xr[j-1] + ys;
          y_next[j] = yr[j-1] - xs;
          z_next[j] = zr[j-1] + rom;
        end else begin
          x_next[j] = xr[j-1] - ys;
          y_next[j] = yr[j-1] + xs;
          z_next[j] = zr[j-1] - rom;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < STAGES; j++) begin
        xr[j] <= x_next[j];
        yr[j] <= y_next[j];
        zr[j] <= z_next[j];
      end
    end
  end

  assign angle = zr[STAGES-1];

endmodule

FILE: rtl/core/two_link_inverse_kinematics.sv
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset (rst, synchronous): clears the stage valid bits and restores link
// lengths to 1.0 and offsets to zero; no memory clearing is needed.
module two_link_inverse_kinematics (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tlik_pkg::ik_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tlik_pkg::ik_out_t out_data,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [23:0]      cfg_data
);

  localparam int LAST     = 133;
  localparam int D2_DLY   = 32;
  localparam int SGN_DLY  = 32;
  localparam int C_DLY    = 34;
  localparam int ALP_DLY  = 102;
  localparam int FLAG_DLY = 97;
  localparam int ZERO_DLY = 130;

  localparam logic signed [35:0] THREE_HALF_PI = 36'(3 * tlik_pkg::HALF_PI);
  localparam logic [60:0]        ONE_SQ = 61'h1000000000000000;

  logic [22:0]        upper_len;
  logic [22:0]        lower_len;
  logic signed [23:0] hip_off;
  logic signed [23:0] knee_off;

  logic [LAST:0] vld;
  logic          en;

  assign en        = !vld[LAST] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= 23'd65536;
      lower_len <= 23'd65536;
      hip_off   <= '0;
      knee_off  <= '0;
    end else if (cfg_write) begin
      case (tlik_pkg::cfg_reg_t'(cfg_index))
        tlik_pkg::REG_UPPER_LEN: upper_len <= cfg_data[22:0];
        tlik_pkg::REG_LOWER_LEN: lower_len <= cfg_data[22:0];
        tlik_pkg::REG_HIP_OFF:   hip_off   <= cfg_data;
        tlik_pkg::REG_KNEE_OFF:  knee_off  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  logic [45:0] a2;
  logic [45:0] b2;
  logic [45:0] ab;

  always_ff @(posedge clk) begin
    a2 <= upper_len * upper_len;
    b2 <= lower_len * lower_len;
    ab <= upper_len * lower_len;
  end

  logic signed [24:0] tip_x_ext;
  logic signed [24:0] s0_mx;
  logic signed [23:0] s0_y;

  assign tip_x_ext = {in_data.tip_x[23], in_data.tip_x};

  logic signed [49:0] sqx_full;
  logic signed [47:0] sqy_full;
  logic [46:0]        s1_sqx;
  logic [46:0]        s1_sqy;
  logic [47:0]        s2_d2;

  assign sqx_full = s0_mx * s0_mx;
  assign sqy_full = s0_y * s0_y;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mx  <= in_data.mirror ? -tip_x_ext : tip_x_ext;
      s0_y   <= in_data.tip_y;
      s1_sqx <= sqx_full[46:0];
      s1_sqy <= sqy_full[46:0];
      s2_d2  <= {1'b0, s1_sqx} + {1'b0, s1_sqy};
    end
  end

  logic signed [tlik_pkg::ANG_W-1:0] alpha;

  tlik_cordic u_cordic_alpha (
    .clk   (clk),
    .en    (en),
    .x_in  ({{3{s0_mx[24]}}, s0_mx, 24'd0}),
    .y_in  ({{4{s0_y[23]}}, s0_y, 24'd0}),
    .angle (alpha)
  );

  logic [31:0] dq;

  tlik_isqrt u_isqrt_dist (
    .clk  (clk),
    .en   (en),
    .rad  ({s2_d2, 16'd0}),
    .root (dq)
  );

  logic [47:0] d2_dl [D2_DLY];
  logic        zero_dl [ZERO_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      d2_dl[0]   <= s2_d2;
      zero_dl[0] <= s2_d2 == '0;
      for (int i = 1; i < D2_DLY; i++) d2_dl[i] <= d2_dl[i-1];
      for (int i = 1; i < ZERO_DLY; i++) zero_dl[i] <= zero_dl[i-1];
    end
  end

  logic [54:0]        adq;
  logic signed [49:0] a2_ext;
  logic signed [49:0] b2_ext;
  logic signed [49:0] d2_ext;
  logic signed [49:0] nb_core;
  logic signed [49:0] ng_core;
  logic signed [57:0] s35_nb;
  logic signed [57:0] s35_ng;
  logic [56:0]        s35_db;
  logic [56:0]        s35_dg;

  assign adq     = upper_len * dq;
  assign a2_ext  = {4'd0, a2};
  assign b2_ext  = {4'd0, b2};
  assign d2_ext  = {2'd0, d2_dl[D2_DLY-1]};
  assign nb_core = a2_ext + d2_ext - b2_ext;
  assign ng_core = a2_ext + b2_ext - d2_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      s35_nb <= {nb_core, 8'd0};
      s35_ng <= {{8{ng_core[49]}}, ng_core};
      s35_db <= {1'b0, adq, 1'b0};
      s35_dg <= {10'd0, ab, 1'b0};
    end
  end

  logic signed [57:0] nb_abs;
  logic signed [57:0] ng_abs;
  logic               clamp_b;
  logic               clamp_g;
  logic [56:0]        s36_mag_b;
  logic [56:0]        s36_mag_g;
  logic [56:0]        s36_den_b;
  logic [56:0]        s36_den_g;

  assign nb_abs  = s35_nb[57] ? -s35_nb : s35_nb;
  assign ng_abs  = s35_ng[57] ? -s35_ng : s35_ng;
  assign clamp_b = (s35_db == '0) || (nb_abs[56:0] > s35_db);
  assign clamp_g = (s35_dg == '0) || (ng_abs[56:0] > s35_dg);

  logic [3:0] sgn_dl  [SGN_DLY];
  logic       flag_dl [FLAG_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      s36_mag_b  <= clamp_b ? '0 : nb_abs[56:0];
      s36_mag_g  <= clamp_g ? '0 : ng_abs[56:0];
      s36_den_b  <= s35_db;
      s36_den_g  <= s35_dg;
      sgn_dl[0]  <= {s35_nb[57], clamp_b, s35_ng[57], clamp_g};
      flag_dl[0] <= clamp_b || clamp_g;
      for (int i = 1; i < SGN_DLY; i++) sgn_dl[i] <= sgn_dl[i-1];
      for (int i = 1; i < FLAG_DLY; i++) flag_dl[i] <= flag_dl[i-1];
    end
  end

  logic [30:0] q_b;
  logic [30:0] q_g;

  tlik_divider u_div_beta (
    .clk  (clk),
    .en   (en),
    .mag  (s36_mag_b),
    .den  (s36_den_b),
    .quot (q_b)
  );

  tlik_divider u_div_gamma (
    .clk  (clk),
    .en   (en),
    .mag  (s36_mag_g),
    .den  (s36_den_g),
    .quot (q_g)
  );

  logic [3:0]         sgn;
  logic signed [31:0] qb_s;
  logic signed [31:0] qg_s;
  logic signed [31:0] s68_cb;
  logic signed [31:0] s68_cg;

  assign sgn  = sgn_dl[SGN_DLY-1];
  assign qb_s = {1'b0, q_b};
  assign qg_s = {1'b0, q_g};

  always_ff @(posedge clk) begin
    if (en) begin
      if (sgn[2]) s68_cb <= sgn[3] ? -32'sd1073741824 : 32'sd1073741824;
      else        s68_cb <= sgn[3] ? -qb_s : qb_s;
      if (sgn[0]) s68_cg <= sgn[1] ? -32'sd1073741824 : 32'sd1073741824;
      else        s68_cg <= sgn[1] ? -qg_s : qg_s;
    end
  end

  logic signed [31:0] cb_abs;
  logic signed [31:0] cg_abs;
  logic [60:0]        s69_msq_b;
  logic [60:0]        s69_msq_g;
  logic [61:0]        msq_b_full;
  logic [61:0]        msq_g_full;
  logic [63:0]        s70_rad_b;
  logic [63:0]        s70_rad_g;

  assign cb_abs     = s68_cb[31] ? -s68_cb : s68_cb;
  assign cg_abs     = s68_cg[31] ? -s68_cg : s68_cg;
  assign msq_b_full = cb_abs[30:0] * cb_abs[30:0];
  assign msq_g_full = cg_abs[30:0] * cg_abs[30:0];

  logic signed [31:0] cb_dl [C_DLY];
  logic signed [31:0] cg_dl [C_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      s69_msq_b <= msq_b_full[60:0];
      s69_msq_g <= msq_g_full[60:0];
      s70_rad_b <= {3'd0, ONE_SQ - s69_msq_b};
      s70_rad_g <= {3'd0, ONE_SQ - s69_msq_g};
      cb_dl[0]  <= s68_cb;
      cg_dl[0]  <= s68_cg;
      for (int i = 1; i < C_DLY; i++) begin
        cb_dl[i] <= cb_dl[i-1];
        cg_dl[i] <= cg_dl[i-1];
      end
    end
  end

  logic [31:0] sin_b;
  logic [31:0] sin_g;

  tlik_isqrt u_isqrt_beta (
    .clk  (clk),
    .en   (en),
    .rad  (s70_rad_b),
    .root (sin_b)
  );

  tlik_isqrt u_isqrt_gamma (
    .clk  (clk),
    .en   (en),
    .rad  (s70_rad_g),
    .root (sin_g)
  );

  logic signed [31:0]                cb;
  logic signed [31:0]                cg;
  logic signed [tlik_pkg::ANG_W-1:0] beta;
  logic signed [tlik_pkg::ANG_W-1:0] gamma;

  assign cb = cb_dl[C_DLY-1];
  assign cg = cg_dl[C_DLY-1];

  tlik_cordic u_cordic_beta (
    .clk   (clk),
    .en    (en),
    .x_in  ({{4{cb[31]}}, cb, 16'd0}),
    .y_in  ({4'd0, sin_b, 16'd0}),
    .angle (beta)
  );

  tlik_cordic u_cordic_gamma (
    .clk   (clk),
    .en    (en),
    .x_in  ({{4{cg[31]}}, cg, 16'd0}),
    .y_in  ({4'd0, sin_g, 16'd0}),
    .angle (gamma)
  );

  logic signed [tlik_pkg::ANG_W-1:0] alpha_dl [ALP_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_dl[0] <= alpha;
      for (int i = 1; i < ALP_DLY; i++) alpha_dl[i] <= alpha_dl[i-1];
    end
  end

  logic signed [35:0] alpha_e;
  logic signed [35:0] beta_e;
  logic signed [35:0] gamma_e;
  logic signed [35:0] hip_off_e;
  logic signed [35:0] knee_off_e;
  logic signed [35:0] hp_e;
  logic signed [35:0] s132_hip;
  logic signed [35:0] s132_knee;

  assign alpha_e    = 36'(alpha_dl[ALP_DLY-1]);
  assign beta_e     = 36'(beta);
  assign gamma_e    = 36'(gamma);
  assign hp_e       = 36'(tlik_pkg::HALF_PI);
  assign hip_off_e  = {{4{hip_off[23]}}, hip_off, 8'd0};
  assign knee_off_e = {{4{knee_off[23]}}, knee_off, 8'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      s132_hip  <= alpha_e - beta_e + hp_e - hip_off_e;
      s132_knee <= alpha_e - beta_e - gamma_e + THREE_HALF_PI - knee_off_e;
    end
  end

  function automatic logic signed [23:0] to_q420(input logic signed [35:0] ang);
    logic signed [35:0] t;
    logic signed [23:0] v;
    t = (ang + 36'sd128) >>> 8;
    if (t > 36'sd8388607)       v = 24'sd8388607;
    else if (t < -36'sd8388608) v = -24'sd8388608;
    else                        v = t[23:0];
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_dl[ZERO_DLY-1]) begin
        out_data.hip_angle   <= '0;
        out_data.knee_angle  <= '0;
        out_data.unreachable <= 1'b1;
      end else begin
        out_data.hip_angle   <= to_q420(s132_hip);
        out_data.knee_angle  <= to_q420(s132_knee);
        out_data.unreachable <= flag_dl[FLAG_DLY-1];
      end
    end
  end

endmodule
